>>> design/ft12_pkg.sv
// Shared constants and types for the FT1.2 frame checker.
package ft12_pkg;

    localparam logic [7:0] START_FIXED  = 8'd16;
    localparam logic [7:0] START_VAR    = 8'd104;
    localparam logic [7:0] END_MARK     = 8'd22;
    localparam logic [9:0] VAR_OVERHEAD = 10'd6;
    localparam logic [9:0] FIXED_BASE   = 10'd4;
    localparam logic [8:0] POS_MAX      = 9'd511;
    localparam logic [1:0] ADDR_RESET   = 2'd1;

    typedef enum logic [1:0] {
        KIND_INVALID  = 2'd0,
        KIND_FIXED    = 2'd1,
        KIND_VARIABLE = 2'd2
    } frame_kind_t;

    typedef struct packed {
        logic       dir;
        logic       prm;
        logic       fcb;
        logic       fcv;
        logic       acd;
        logic       dfc;
        logic [3:0] fc;
        logic       fc_ok;
    } ctrl_fields_t;

endpackage

>>> design/ft12_ctrl_decode.sv
// Control byte decoder: station flags, function code and its validity.
module ft12_ctrl_decode
(
    input  logic [7:0]           ctrl_byte,
    input  logic                 enable,
    output ft12_pkg::ctrl_fields_t fields
);
    import ft12_pkg::*;

    always_comb
    begin
        fields = '0;
        if (enable)
        begin
            fields.dir = ctrl_byte[7];
            if (ctrl_byte[7])
            begin
                fields.prm = ctrl_byte[6];
                fields.dfc = ctrl_byte[4];
            end
            else if (ctrl_byte[6])
            begin
                fields.prm = 1'b1;
                fields.fcb = ctrl_byte[5];
                fields.fcv = ctrl_byte[4];
            end
            else
            begin
                fields.acd = ctrl_byte[5];
                fields.dfc = ctrl_byte[4];
            end
            fields.fc    = ctrl_byte[3:0];
            fields.fc_ok = ctrl_byte[3:0] inside {[4'd0:4'd4], [4'd8:4'd11]};
        end
    end

endmodule

>>> design/ft12_frame_checker.sv
// FT1.2 link frame checker top level: byte intake, checksums, result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    data_byte, last_byte
//   out      output     out_valid/out_ready  frame_kind .. function_code_valid
//   cfg      input      cfg_valid/cfg_ready  cfg_data (link address byte count)
//
// One byte per cycle unless blocked; results register on the final byte.
// The result register refills in the cycle it drains, so a stalled output
// blocks intake only while it holds an untaken result.
// Reset clears frame state and sets the address byte count to one.
// Configuration writes are always taken.
module ft12_frame_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] frame_kind,
    output logic       length_match,
    output logic       dir_bit,
    output logic       prm_bit,
    output logic       fcb_bit,
    output logic       fcv_bit,
    output logic       acd_bit,
    output logic       dfc_bit,
    output logic [3:0] function_code,
    output logic       function_code_valid,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);
    import ft12_pkg::*;

    logic [1:0]   addr_bytes_reg;
    logic [8:0]   pos_reg, pos_next;
    logic [7:0]   start_reg, start_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   fsum_reg, fsum_next;
    logic [7:0]   fchk_reg, fchk_next;
    logic [7:0]   vsum_reg, vsum_next;
    logic [7:0]   del0_reg, del1_reg;
    logic [7:0]   fctrl_reg, fctrl_next;
    logic [7:0]   vctrl_reg, vctrl_next;

    logic         out_valid_reg;
    frame_kind_t  kind_reg, kind_next;
    logic         match_reg, match_next;
    ctrl_fields_t ctrl_reg, ctrl_next;

    logic         in_beat;
    logic [8:0]   sum_end;
    logic [9:0]   frame_len;
    logic [9:0]   min_len;
    logic [7:0]   ctrl_sel;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign sum_end   = {7'd0, addr_bytes_reg} + 9'd1;
    assign frame_len = {1'b0, pos_reg} + 10'd1;
    assign min_len   = FIXED_BASE + {8'd0, addr_bytes_reg};

    always_comb
    begin
        start_next = (pos_reg == 9'd0) ? data_byte : start_reg;
        len_next   = (pos_reg == 9'd1) ? data_byte : len_reg;
        fctrl_next = (pos_reg == 9'd1) ? data_byte : fctrl_reg;
        vctrl_next = (pos_reg == 9'd4) ? data_byte : vctrl_reg;
        fsum_next  = (pos_reg >= 9'd1 && pos_reg <= sum_end) ? fsum_reg + data_byte
                                                             : fsum_reg;
        fchk_next  = (pos_reg == sum_end + 9'd1) ? data_byte : fchk_reg;
        vsum_next  = (pos_reg >= 9'd6) ? vsum_reg + del1_reg : vsum_reg;
        pos_next   = (pos_reg != POS_MAX) ? pos_reg + 9'd1 : pos_reg;
    end

    always_comb
    begin
        kind_next = KIND_INVALID;
        if (frame_len >= min_len && data_byte == END_MARK)
        begin
            if (start_next == START_FIXED && fsum_next == fchk_next)
                kind_next = KIND_FIXED;
            else if (start_next == START_VAR && vsum_next == del0_reg)
                kind_next = KIND_VARIABLE;
        end

        match_next = 1'b0;
        ctrl_sel   = 8'd0;
        if (start_next == START_FIXED)
        begin
            match_next = (frame_len == min_len);
            ctrl_sel   = fctrl_next;
        end
        else if (start_next == START_VAR)
        begin
            match_next = (frame_len == {2'd0, len_next} + VAR_OVERHEAD);
            ctrl_sel   = vctrl_next;
        end
    end

    ft12_ctrl_decode u_ctrl_decode
    (
        .ctrl_byte (ctrl_sel),
        .enable    (match_next),
        .fields    (ctrl_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_bytes_reg <= ADDR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            addr_bytes_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            fsum_reg  <= '0;
            fchk_reg  <= '0;
            vsum_reg  <= '0;
            del0_reg  <= '0;
            del1_reg  <= '0;
            fctrl_reg <= '0;
            vctrl_reg <= '0;
        end
        else if (in_beat)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                start_reg <= '0;
                len_reg   <= '0;
                fsum_reg  <= '0;
                fchk_reg  <= '0;
                vsum_reg  <= '0;
                del0_reg  <= '0;
                del1_reg  <= '0;
                fctrl_reg <= '0;
                vctrl_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                fsum_reg  <= fsum_next;
                fchk_reg  <= fchk_next;
                vsum_reg  <= vsum_next;
                del0_reg  <= data_byte;
                del1_reg  <= del0_reg;
                fctrl_reg <= fctrl_next;
                vctrl_reg <= vctrl_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_beat && last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && last_byte)
        begin
            kind_reg  <= kind_next;
            match_reg <= match_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign frame_kind          = kind_reg;
    assign length_match        = match_reg;
    assign dir_bit             = ctrl_reg.dir;
    assign prm_bit             = ctrl_reg.prm;
    assign fcb_bit             = ctrl_reg.fcb;
    assign fcv_bit             = ctrl_reg.fcv;
    assign acd_bit             = ctrl_reg.acd;
    assign dfc_bit             = ctrl_reg.dfc;
    assign function_code       = ctrl_reg.fc;
    assign function_code_valid = ctrl_reg.fc_ok;

endmodule

>>> dv/tb_ft12_frame_checker.sv
`timescale 1ns / 1ps
// Testbench for the FT1.2 frame checker: framed byte traffic checked against a byte-level predictor.
module tb_ft12_frame_checker;
    import ft12_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 100;
    localparam int DRAIN_CYCLES = 3;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        frame_kind_t  kind;
        logic         match;
        ctrl_fields_t ctrl;
    } frame_result_t;

    typedef enum int {
        FR_FIXED,
        FR_VARIABLE,
        FR_BAD_SUM,
        FR_BAD_START,
        FR_BAD_END,
        FR_BAD_LENGTH,
        FR_TRUNCATED,
        FR_EXTENDED,
        FR_NOISE
    } frame_shape_t;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] frame_kind;
    logic       length_match;
    logic       dir_bit;
    logic       prm_bit;
    logic       fcb_bit;
    logic       fcv_bit;
    logic       acd_bit;
    logic       dfc_bit;
    logic [3:0] function_code;
    logic       function_code_valid;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'd0;

    // predictor state
    logic [1:0] addr_bytes = ADDR_RESET;
    logic [8:0] byte_pos = '0;
    logic [7:0] start_b = '0;
    logic [7:0] len_field = '0;
    logic [7:0] fixed_sum = '0;
    logic [7:0] fixed_check = '0;
    logic [7:0] var_sum = '0;
    logic [7:0] prev_byte = '0;
    logic [7:0] prev2_byte = '0;
    logic [7:0] fixed_ctrl = '0;
    logic [7:0] var_ctrl = '0;

    frame_result_t pending_results[$];
    int            fail_count = 0;
    int            bytes_sent = 0;
    int            burst_left = 0;
    int            cycle_count = 0;
    logic [5:0]    rx_phase = '0;
    rx_mode_t      rx_mode = RX_FLOW;

    ft12_frame_checker u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .frame_kind          (frame_kind),
        .length_match        (length_match),
        .dir_bit             (dir_bit),
        .prm_bit             (prm_bit),
        .fcb_bit             (fcb_bit),
        .fcv_bit             (fcv_bit),
        .acd_bit             (acd_bit),
        .dfc_bit             (dfc_bit),
        .function_code       (function_code),
        .function_code_valid (function_code_valid),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == '0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_FLOW:   out_ready <= 1'b1;
            RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= rx_phase[2];
        endcase
    end

    task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no frame pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("frame_kind", 4'(want.kind), 4'(frame_kind));
                check_field("length_match", 4'(want.match), 4'(length_match));
                check_field("dir_bit", 4'(want.ctrl.dir), 4'(dir_bit));
                check_field("prm_bit", 4'(want.ctrl.prm), 4'(prm_bit));
                check_field("fcb_bit", 4'(want.ctrl.fcb), 4'(fcb_bit));
                check_field("fcv_bit", 4'(want.ctrl.fcv), 4'(fcv_bit));
                check_field("acd_bit", 4'(want.ctrl.acd), 4'(acd_bit));
                check_field("dfc_bit", 4'(want.ctrl.dfc), 4'(dfc_bit));
                check_field("function_code", want.ctrl.fc, function_code);
                check_field("function_code_valid", 4'(want.ctrl.fc_ok),
                            4'(function_code_valid));
            end
        end
    end

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [8:0]    p;
        logic [9:0]    n;
        logic [7:0]    var_check;
        logic [7:0]    c;
        frame_result_t r;
        p = byte_pos;
        if (p == 0)
            start_b = b;
        if (p == 1)
        begin
            len_field = b;
            fixed_ctrl = b;
        end
        if (p == 4)
            var_ctrl = b;
        if (p >= 1 && p <= 1 + addr_bytes)
            fixed_sum += b;
        if (p == 2 + addr_bytes)
            fixed_check = b;
        if (p >= 6)
            var_sum += prev2_byte;
        var_check = prev_byte;
        prev2_byte = prev_byte;
        prev_byte = b;
        if (byte_pos != POS_MAX)
            byte_pos++;
        if (!last)
            return;

        n = {1'b0, p} + 10'd1;
        r = '0;
        r.kind = KIND_INVALID;
        if (n >= FIXED_BASE + addr_bytes && b == END_MARK)
        begin
            if (start_b == START_FIXED && fixed_sum == fixed_check)
                r.kind = KIND_FIXED;
            else if (start_b == START_VAR && var_sum == var_check)
                r.kind = KIND_VARIABLE;
        end
        c = '0;
        if (start_b == START_FIXED)
        begin
            r.match = (n == FIXED_BASE + addr_bytes);
            c = fixed_ctrl;
        end
        else if (start_b == START_VAR)
        begin
            r.match = (n == {2'b00, len_field} + VAR_OVERHEAD);
            c = var_ctrl;
        end
        if (r.match)
        begin
            r.ctrl.dir = c[7];
            if (c[7])
            begin
                r.ctrl.prm = c[6];
                r.ctrl.dfc = c[4];
            end
            else if (c[6])
            begin
                r.ctrl.prm = 1'b1;
                r.ctrl.fcb = c[5];
                r.ctrl.fcv = c[4];
            end
            else
            begin
                r.ctrl.acd = c[5];
                r.ctrl.dfc = c[4];
            end
            r.ctrl.fc = c[3:0];
            r.ctrl.fc_ok = (c[3:0] <= 4'd4) || (c[3:0] >= 4'd8 && c[3:0] <= 4'd11);
        end
        pending_results.push_back(r);

        byte_pos = '0;
        start_b = '0;
        len_field = '0;
        fixed_sum = '0;
        fixed_check = '0;
        var_sum = '0;
        prev_byte = '0;
        prev2_byte = '0;
        fixed_ctrl = '0;
        var_ctrl = '0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t fr);
        foreach (fr[i])
            send_byte(fr[i], i == fr.size() - 1);
    endtask

    // hold intake until every pending result has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_link_addr(input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        addr_bytes = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic byte_q_t fixed_frame(input logic [7:0] ctrl);
        byte_q_t    fr;
        logic [7:0] sum;
        logic [7:0] a;
        fr = {START_FIXED, ctrl};
        sum = ctrl;
        repeat (addr_bytes)
        begin
            a = 8'($urandom);
            fr.push_back(a);
            sum += a;
        end
        fr.push_back(sum);
        fr.push_back(END_MARK);
        return fr;
    endfunction

    function automatic byte_q_t variable_frame(input int user_len, input logic [7:0] ctrl);
        byte_q_t    fr;
        int         len;
        logic [7:0] len_b;
        logic [7:0] sum;
        logic [7:0] a;
        len = 1 + addr_bytes + user_len;
        if (len > 255)
            len = 255;
        len_b = 8'(len);
        fr = {START_VAR, len_b, len_b, START_VAR, ctrl};
        sum = ctrl;
        repeat (len - 1)
        begin
            a = 8'($urandom);
            fr.push_back(a);
            sum += a;
        end
        fr.push_back(sum);
        fr.push_back(END_MARK);
        return fr;
    endfunction

    task automatic random_frame();
        byte_q_t      fr;
        frame_shape_t shape;
        int           roll;
        int           user_len;
        int           k;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            shape = FR_FIXED;
        else if (roll < 65)
            shape = FR_VARIABLE;
        else
            shape = frame_shape_t'(FR_BAD_SUM + (roll - 65) / 5);
        user_len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
        if (shape == FR_FIXED || (shape != FR_VARIABLE && shape != FR_BAD_LENGTH
                && $urandom_range(0, 1) == 0))
            fr = fixed_frame(8'($urandom));
        else
            fr = variable_frame(user_len, 8'($urandom));
        case (shape)
            FR_BAD_SUM:    fr[fr.size() - 2] ^= 8'($urandom_range(1, 255));
            FR_BAD_START:  fr[0] = 8'($urandom);
            FR_BAD_END:    fr[fr.size() - 1] ^= 8'($urandom_range(1, 255));
            FR_BAD_LENGTH: fr[1] ^= 8'($urandom_range(1, 255));
            FR_TRUNCATED:
            begin
                k = $urandom_range(1, fr.size() - 1);
                repeat (k) void'(fr.pop_back());
                if ($urandom_range(0, 1) == 0)
                    fr[fr.size() - 1] = END_MARK;
            end
            FR_EXTENDED:
            begin
                k = $urandom_range(1, 4);
                repeat (k) fr.insert(fr.size() - 1, 8'($urandom));
            end
            FR_NOISE:
            begin
                fr.delete();
                k = $urandom_range(1, 12);
                repeat (k) fr.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 0)
                    fr[0] = ($urandom_range(0, 1) == 0) ? START_FIXED : START_VAR;
                if ($urandom_range(0, 1) == 0)
                    fr[fr.size() - 1] = END_MARK;
            end
            default: ;
        endcase
        send_frame(fr);
    endtask

    task automatic test_reset_defaults();
        byte_q_t fr;
        send_frame(fixed_frame(8'h00));
        send_frame(variable_frame(0, 8'hFF));
        fr = {END_MARK};
        send_frame(fr);
        fr = fixed_frame(8'h7B);
        fr[fr.size() - 2] ^= 8'h01;
        send_frame(fr);
        wait_idle();
        write_link_addr(2'd0);
        send_frame(fixed_frame(8'h4C));
        wait_idle();
    endtask

    task automatic test_addr_byte_counts();
        logic [1:0] setting[4] = '{2'd0, 2'd3, 2'd2, 2'd1};
        foreach (setting[i])
        begin
            write_link_addr(setting[i]);
            send_frame(fixed_frame(8'($urandom)));
            send_frame(variable_frame($urandom_range(0, 4), 8'($urandom)));
            random_frame();
            wait_idle();
        end
    endtask

    task automatic test_long_frames();
        byte_q_t    fr;
        logic [7:0] sum;
        write_link_addr(2'd2);
        // run the position counter into saturation with a valid variable checksum
        fr = {START_VAR};
        repeat (511) fr.push_back(8'($urandom));
        fr.push_back(END_MARK);
        sum = '0;
        for (int i = 4; i <= fr.size() - 3; i++)
            sum += fr[i];
        fr[fr.size() - 2] = sum;
        send_frame(fr);
        wait_idle();
        write_link_addr(ADDR_RESET);
    endtask

    task automatic test_random_traffic();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            random_frame();
            if ($urandom_range(0, 11) == 0)
            begin
                wait_idle();
                if ($urandom_range(0, 1) == 0)
                    write_link_addr(2'($urandom_range(0, 3)));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_addr_byte_counts();
        test_long_frames();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
